// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define FBBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbba assertion failed");

// next-cycle implication, disabled in reset
`define FBBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbba assertion failed");

`endif

// ===== src/fbba_pkg.sv =====
// ----------------------------------------------------------------------------
// fbba_pkg
// shared widths, codes and defaults of the free block bitmap allocator
// ----------------------------------------------------------------------------
package fbba_pkg;

    // fixed field widths
    localparam int CMD_W  = 2;
    localparam int BLK_W  = 16;
    localparam int CNT_W  = 17;
    localparam int STAT_W = 2;

    // parameter defaults
    localparam int BLOCK_COUNT_DEF   = 65536;
    localparam int RESERVED_TAIL_DEF = 8;
    localparam int MAP_WORD_BITS_DEF = 64;
    localparam int MAP_DEPTH_DEF     = 1024;
    localparam int MAP_ADDR_W_DEF    = 10;
    localparam int BIT_POS_W_DEF     = 6;

    // bits examined per cycle by the bit finder
    localparam int FIND_CHUNK = 8;
    localparam int FIND_IDX_W = 3;

    // reciprocal shift of the block number split
    localparam int DIV_SHIFT = 24;
    localparam int PROD_W    = 40;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_IN_USE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

endpackage

// ===== src/fbba_if.sv =====
// ----------------------------------------------------------------------------
// fbba_if
// command and response channels of the allocator
// ----------------------------------------------------------------------------
interface fbba_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [fbba_pkg::CMD_W-1:0]     command;
    logic [fbba_pkg::BLK_W-1:0]     target_block;

    modport source (output valid, output command, output target_block, input ready);
    modport sink   (input valid, input command, input target_block, output ready);
endinterface

interface fbba_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [fbba_pkg::STAT_W-1:0]    status;
    logic [fbba_pkg::BLK_W-1:0]     granted_block;
    logic [fbba_pkg::CNT_W-1:0]     used_count;
    logic [fbba_pkg::CNT_W-1:0]     free_count;

    modport source (output valid, output status, output granted_block,
                    output used_count, output free_count, input ready);
    modport sink   (input valid, input status, input granted_block,
                    input used_count, input free_count, output ready);
endinterface

// ===== src/free_block_bitmap_allocator_top.sv =====
// ----------------------------------------------------------------------------
// free_block_bitmap_allocator_top
// bitmap block allocator: allocate lowest free, request named, release named
// ----------------------------------------------------------------------------
// request and release: DIV0, DIV1 and DIV2 split the target, RD reads the word,
//   MOD updates it, DONE loads the response; a target past the map goes to DONE
// allocate: one map word read per cycle until a word holds a free block,
//   FIND picks its lowest free bit, ALLOC sets it; a full map gives status full
// one command at a time; ready is low while a command is in progress
// after reset a clearing pass writes every map word, reserved tail bits set
// ----------------------------------------------------------------------------
module free_block_bitmap_allocator_top #(
    parameter int BLOCK_COUNT   = fbba_pkg::BLOCK_COUNT_DEF,
    parameter int RESERVED_TAIL = fbba_pkg::RESERVED_TAIL_DEF,
    parameter int MAP_WORD_BITS = fbba_pkg::MAP_WORD_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    fbba_cmd_if.sink   cmd,
    fbba_rsp_if.source rsp
);

    // map geometry
    localparam int MAP_DEPTH  = (BLOCK_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int ADDR_W     = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int BIT_W      = $clog2(MAP_WORD_BITS);
    localparam int LAST_VALID = BLOCK_COUNT - (MAP_DEPTH - 1) * MAP_WORD_BITS;
    localparam int RECIP      = (1 << fbba_pkg::DIV_SHIFT) / MAP_WORD_BITS;
    localparam int BLK_W      = fbba_pkg::BLK_W;
    localparam int CNT_W      = fbba_pkg::CNT_W;
    localparam int PROD_W     = fbba_pkg::PROD_W;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_DEPTH - 1);
    localparam logic [CNT_W-1:0]  BC_C      = CNT_W'(BLOCK_COUNT);
    localparam logic [CNT_W-1:0]  RES_START = CNT_W'(BLOCK_COUNT - RESERVED_TAIL);
    localparam logic [CNT_W-1:0]  RES_INIT  = CNT_W'(RESERVED_TAIL);
    localparam logic [BLK_W-1:0]  WB_BLK    = BLK_W'(MAP_WORD_BITS);

    // sequencer states
    typedef enum logic [10:0] {
        S_CLEAR = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_DIV0  = 11'b000_0000_0100,
        S_DIV1  = 11'b000_0000_1000,
        S_DIV2  = 11'b000_0001_0000,
        S_RD    = 11'b000_0010_0000,
        S_MOD   = 11'b000_0100_0000,
        S_SCAN  = 11'b000_1000_0000,
        S_FIND  = 11'b001_0000_0000,
        S_ALLOC = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // control registers
    logic [ADDR_W-1:0]  scan_addr_reg;
    logic [CNT_W-1:0]   base_reg;
    logic               rd_valid_reg;
    logic [CNT_W-1:0]   used_reg;
    logic               out_valid_reg;

    // command and datapath registers
    logic [fbba_pkg::CMD_W-1:0]  cmd_reg;
    logic [BLK_W-1:0]            tgt_reg;
    logic [fbba_pkg::STAT_W-1:0] status_reg;
    logic [BLK_W-1:0]            granted_reg;
    logic [PROD_W-1:0]           prod_reg;
    logic [BLK_W-1:0]            quot_reg;
    logic [BLK_W-1:0]            qw_reg;
    logic [ADDR_W-1:0]           word_addr_reg;
    logic [BIT_W-1:0]            bit_reg;
    logic [ADDR_W-1:0]           rd_word_reg;
    logic [ADDR_W-1:0]           found_addr_reg;
    logic [MAP_WORD_BITS-1:0]    found_word_reg;
    logic [BIT_W-1:0]            found_pos_reg;

    // output register
    logic [fbba_pkg::STAT_W-1:0] out_status_reg;
    logic [BLK_W-1:0]            out_granted_reg;
    logic [CNT_W-1:0]            out_used_reg;
    logic [CNT_W-1:0]            out_free_reg;

    // ram port
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [MAP_WORD_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [MAP_WORD_BITS-1:0] ram_rdata;

    // misc datapath
    logic                     cmd_xfer;
    logic                     tgt_oor;
    logic                     out_load;
    logic [MAP_WORD_BITS-1:0] clr_word;
    logic [MAP_WORD_BITS-1:0] last_mask;
    logic [MAP_WORD_BITS-1:0] scan_free;
    logic                     scan_hit;
    logic                     scan_last;
    logic [MAP_WORD_BITS-1:0] bit_onehot;
    logic                     bit_set;
    logic                     mod_write;
    logic [BLK_W-1:0]         rem;
    logic [BLK_W-1:0]         rem_fix;
    logic [BLK_W-1:0]         quot_fix;
    logic [BLK_W-1:0]         alloc_blk;
    logic                     find_done;
    logic [BIT_W-1:0]         find_pos;

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_xfer  = cmd.valid && cmd.ready;
    // a target past the map is rejected by request and ignored by release
    assign tgt_oor   = ({1'b0, cmd.target_block} >= BC_C);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    // reset image of the word being cleared: reserved tail bits set
    always_comb
    begin
        for (int b = 0; b < MAP_WORD_BITS; b++)
        begin
            clr_word[b] = ((base_reg + CNT_W'(b)) >= RES_START) &&
                          ((base_reg + CNT_W'(b)) < BC_C);
        end
    end

    // bits past the last block never count as free
    always_comb
    begin
        for (int b = 0; b < MAP_WORD_BITS; b++)
        begin
            last_mask[b] = (b < LAST_VALID);
        end
    end

    assign scan_last = (rd_word_reg == LAST_ADDR);
    assign scan_free = ~ram_rdata & (scan_last ? last_mask : '1);
    assign scan_hit  = rd_valid_reg && (scan_free != '0);

    // named block access
    assign bit_onehot = MAP_WORD_BITS'(1) << bit_reg;
    assign bit_set    = ram_rdata[bit_reg];
    assign mod_write  = ((cmd_reg == fbba_pkg::CMD_REQUEST) && !bit_set) ||
                        ((cmd_reg == fbba_pkg::CMD_RELEASE) && bit_set);

    // block number split: reciprocal estimate is low by at most one
    assign rem      = tgt_reg - qw_reg;
    assign quot_fix = (rem >= WB_BLK) ? quot_reg + 1'b1 : quot_reg;
    assign rem_fix  = (rem >= WB_BLK) ? rem - WB_BLK : rem;

    assign alloc_blk = BLK_W'(BLK_W'(found_addr_reg) * WB_BLK) + BLK_W'(found_pos_reg);

    // ram port steering
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = scan_addr_reg;
        ram_wdata = clr_word;
        ram_raddr = (state_reg == S_RD) ? word_addr_reg : scan_addr_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
            end
            S_MOD:
            begin
                ram_we    = mod_write;
                ram_waddr = word_addr_reg;
                ram_wdata = (cmd_reg == fbba_pkg::CMD_REQUEST) ? (ram_rdata | bit_onehot)
                                                               : (ram_rdata & ~bit_onehot);
            end
            S_ALLOC:
            begin
                ram_we    = 1'b1;
                ram_waddr = found_addr_reg;
                ram_wdata = found_word_reg | (MAP_WORD_BITS'(1) << found_pos_reg);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (scan_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    unique case (cmd.command)
                        fbba_pkg::CMD_ALLOC:   state_next = S_SCAN;
                        fbba_pkg::CMD_REQUEST,
                        fbba_pkg::CMD_RELEASE: state_next = tgt_oor ? S_DONE : S_DIV0;
                        default:               state_next = S_DONE;
                    endcase
                end
            end
            S_DIV0:  state_next = S_DIV1;
            S_DIV1:  state_next = S_DIV2;
            S_DIV2:  state_next = S_RD;
            S_RD:    state_next = S_MOD;
            S_MOD:   state_next = S_DONE;
            S_SCAN:
            begin
                priority if (scan_hit)
                begin
                    state_next = S_FIND;
                end
                else if (rd_valid_reg && scan_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_FIND:
            begin
                if (find_done)
                begin
                    state_next = S_ALLOC;
                end
            end
            S_ALLOC: state_next = S_DONE;
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            scan_addr_reg <= '0;
            base_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            used_reg      <= RES_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_CLEAR:
                begin
                    // the address counter doubles as the clear pointer
                    scan_addr_reg <= (scan_addr_reg == LAST_ADDR) ? '0
                                                                  : scan_addr_reg + 1'b1;
                    base_reg      <= base_reg + CNT_W'(MAP_WORD_BITS);
                end
                S_IDLE:
                begin
                    scan_addr_reg <= '0;
                    rd_valid_reg  <= 1'b0;
                end
                S_SCAN:
                begin
                    rd_valid_reg <= 1'b1;
                    if (scan_addr_reg != LAST_ADDR)
                    begin
                        scan_addr_reg <= scan_addr_reg + 1'b1;
                    end
                end
                S_MOD:
                begin
                    // count moves only when a bit really flips
                    if (mod_write)
                    begin
                        used_reg <= (cmd_reg == fbba_pkg::CMD_REQUEST) ? used_reg + 1'b1
                                                                       : used_reg - 1'b1;
                    end
                end
                S_ALLOC:
                begin
                    used_reg <= used_reg + 1'b1;
                end
                default:
                begin
                end
            endcase

            priority if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            else
            begin
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    cmd_reg     <= cmd.command;
                    tgt_reg     <= cmd.target_block;
                    granted_reg <= '0;
                    status_reg  <= ((cmd.command == fbba_pkg::CMD_REQUEST) && tgt_oor)
                                   ? fbba_pkg::STAT_IN_USE : fbba_pkg::STAT_OK;
                end
            end
            S_DIV0:
            begin
                prod_reg <= PROD_W'(tgt_reg) * PROD_W'(RECIP);
            end
            S_DIV1:
            begin
                quot_reg <= prod_reg[fbba_pkg::DIV_SHIFT +: BLK_W];
                qw_reg   <= BLK_W'(prod_reg[fbba_pkg::DIV_SHIFT +: BLK_W] * WB_BLK);
            end
            S_DIV2:
            begin
                word_addr_reg <= quot_fix[ADDR_W-1:0];
                bit_reg       <= rem_fix[BIT_W-1:0];
            end
            S_MOD:
            begin
                if (cmd_reg == fbba_pkg::CMD_REQUEST)
                begin
                    if (bit_set)
                    begin
                        status_reg <= fbba_pkg::STAT_IN_USE;
                    end
                    else
                    begin
                        granted_reg <= tgt_reg;
                    end
                end
            end
            S_SCAN:
            begin
                rd_word_reg <= scan_addr_reg;
                priority if (scan_hit)
                begin
                    found_addr_reg <= rd_word_reg;
                    found_word_reg <= ram_rdata;
                end
                else if (rd_valid_reg && scan_last)
                begin
                    status_reg <= fbba_pkg::STAT_FULL;
                end
                else
                begin
                end
            end
            S_FIND:
            begin
                if (find_done)
                begin
                    found_pos_reg <= find_pos;
                end
            end
            S_ALLOC:
            begin
                granted_reg <= alloc_blk;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_status_reg  <= status_reg;
                    out_granted_reg <= granted_reg;
                    out_used_reg    <= used_reg;
                    out_free_reg    <= BC_C - used_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.granted_block = out_granted_reg;
    assign rsp.used_count    = out_used_reg;
    assign rsp.free_count    = out_free_reg;

    fbba_map_ram #(
        .DEPTH  (MAP_DEPTH),
        .WIDTH  (MAP_WORD_BITS),
        .ADDR_W (ADDR_W)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // bit search, started on the first word holding a free block
    fbba_bit_find #(
        .WIDTH (MAP_WORD_BITS),
        .POS_W (BIT_W)
    ) u_bit_find (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     ((state_reg == S_SCAN) && scan_hit),
        .free_bits (scan_free),
        .done      (find_done),
        .pos       (find_pos)
    );

endmodule

// ===== src/fbba_map_ram.sv =====
// ----------------------------------------------------------------------------
// fbba_map_ram
// usage map storage, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module fbba_map_ram #(
    parameter int DEPTH  = fbba_pkg::MAP_DEPTH_DEF,
    parameter int WIDTH  = fbba_pkg::MAP_WORD_BITS_DEF,
    parameter int ADDR_W = fbba_pkg::MAP_ADDR_W_DEF
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/fbba_bit_find.sv =====
// ----------------------------------------------------------------------------
// fbba_bit_find
// lowest set bit of a word, one byte-wide chunk per cycle
// ----------------------------------------------------------------------------
module fbba_bit_find #(
    parameter int WIDTH = fbba_pkg::MAP_WORD_BITS_DEF,
    parameter int POS_W = fbba_pkg::BIT_POS_W_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] free_bits,
    output logic             done,
    output logic [POS_W-1:0] pos
);

    localparam int CH = fbba_pkg::FIND_CHUNK;

    logic [WIDTH-1:0]                  bits_reg;
    logic [POS_W-1:0]                  pos_reg;
    logic                              busy_reg;
    logic [fbba_pkg::FIND_IDX_W-1:0]   idx;
    logic                              hit;

    // priority encode the low chunk
    always_comb
    begin
        idx = '0;
        hit = 1'b0;
        for (int b = CH - 1; b >= 0; b--)
        begin
            if (bits_reg[b])
            begin
                idx = fbba_pkg::FIND_IDX_W'(b);
                hit = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            priority if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && hit)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bits_reg <= free_bits;
            pos_reg  <= '0;
        end
        else if (busy_reg && !hit)
        begin
            bits_reg <= bits_reg >> CH;
            pos_reg  <= pos_reg + POS_W'(CH);
        end
    end

    assign done = busy_reg && hit;
    assign pos  = pos_reg + POS_W'(idx);

endmodule

// ===== src/fbba_checker.sv =====
// ----------------------------------------------------------------------------
// fbba_checker
// port-level checks of the allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbba_checker #(
    parameter int BLOCK_COUNT = fbba_pkg::BLOCK_COUNT_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [fbba_pkg::STAT_W-1:0]   rsp_status,
    input logic [fbba_pkg::BLK_W-1:0]    rsp_granted_block,
    input logic [fbba_pkg::CNT_W-1:0]    rsp_used_count,
    input logic [fbba_pkg::CNT_W-1:0]    rsp_free_count
);

    localparam int SUM_W = fbba_pkg::CNT_W + 1;
    localparam int PAY_W = fbba_pkg::STAT_W + fbba_pkg::BLK_W + 2 * fbba_pkg::CNT_W;

    logic [SUM_W-1:0] count_sum;
    logic [PAY_W-1:0] rsp_payload;
    logic             rejected;
    logic             full_status;
    logic             rsp_stalled;

    assign count_sum   = SUM_W'(rsp_used_count) + SUM_W'(rsp_free_count);
    assign rsp_payload = {rsp_status, rsp_granted_block, rsp_used_count, rsp_free_count};
    assign rejected    = (rsp_status == fbba_pkg::STAT_IN_USE) ||
                         (rsp_status == fbba_pkg::STAT_FULL);
    assign full_status = (rsp_status == fbba_pkg::STAT_FULL);
    assign rsp_stalled = rsp_valid && !rsp_ready;

    // used plus free always covers the whole map
    `FBBA_ASSERT_IMP(a_count_sum, clk, rst_n, rsp_valid, count_sum == SUM_W'(BLOCK_COUNT))

    // a refused command grants nothing
    `FBBA_ASSERT_IMP(a_reject_no_grant, clk, rst_n, rsp_valid && rejected, rsp_granted_block == '0)

    // full map means no free block
    `FBBA_ASSERT_IMP(a_full_no_free, clk, rst_n, rsp_valid && full_status, rsp_free_count == '0)

    // a stalled response holds
    `FBBA_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_stalled, rsp_valid && $stable(rsp_payload))

    // one command at a time: ready drops after a command transfer
    `FBBA_ASSERT_NXT(a_one_cmd, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready)

endmodule

bind free_block_bitmap_allocator_top fbba_checker #(
    .BLOCK_COUNT (BLOCK_COUNT)
) u_fbba_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd.valid),
    .cmd_ready         (cmd.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_granted_block (rsp.granted_block),
    .rsp_used_count    (rsp.used_count),
    .rsp_free_count    (rsp.free_count)
);

// ===== verif/free_block_bitmap_allocator_top_test.sv =====
// ----------------------------------------------------------------------------
// free_block_bitmap_allocator_top_test
// self-checking bench for the bitmap block allocator: drives allocate,
// request, release and no-op commands, predicts every response from a
// private copy of the usage map and checks status, block and both counts
// ----------------------------------------------------------------------------
module free_block_bitmap_allocator_top_test;

    // field widths and codes of the block
    localparam int CMD_W  = fbba_pkg::CMD_W;
    localparam int BLK_W  = fbba_pkg::BLK_W;
    localparam int CNT_W  = fbba_pkg::CNT_W;
    localparam int STAT_W = fbba_pkg::STAT_W;

    localparam logic [CMD_W-1:0]  CMD_ALLOC   = fbba_pkg::CMD_ALLOC;
    localparam logic [CMD_W-1:0]  CMD_REQUEST = fbba_pkg::CMD_REQUEST;
    localparam logic [CMD_W-1:0]  CMD_RELEASE = fbba_pkg::CMD_RELEASE;
    localparam logic [STAT_W-1:0] STAT_OK     = fbba_pkg::STAT_OK;
    localparam logic [STAT_W-1:0] STAT_IN_USE = fbba_pkg::STAT_IN_USE;
    localparam logic [STAT_W-1:0] STAT_FULL   = fbba_pkg::STAT_FULL;

    // geometry of the default build
    localparam int NUM_BLOCKS = fbba_pkg::BLOCK_COUNT_DEF;
    localparam int TAIL_BLOCKS = fbba_pkg::RESERVED_TAIL_DEF;
    localparam int WORD_BITS = fbba_pkg::MAP_WORD_BITS_DEF;
    localparam int MAP_WORDS = fbba_pkg::MAP_DEPTH_DEF;

    // the spare command code, treated as a no-op by the block
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    // longest run of cycles with no transfer on either channel
    localparam int WATCHDOG_LIMIT = 20000;
    // cycles the receiver holds off during the pressure test
    localparam int HOLD_CYCLES = 300;
    // settle time after the last response
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BLK_W-1:0]  granted_block;
        logic [CNT_W-1:0]  used_count;
        logic [CNT_W-1:0]  free_count;
    } alloc_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fbba_cmd_if cmd_ch ();
    fbba_rsp_if rsp_ch ();

    free_block_bitmap_allocator_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // predicted usage map, one bit per block, and its population count
    bit [WORD_BITS-1:0] map_words [MAP_WORDS];
    int                 blocks_used;

    // responses still owed by the block, oldest first
    alloc_result_t      expected_responses [$];
    // blocks granted so far, used to aim requests and releases at used blocks
    logic [BLK_W-1:0]   granted_history [$];

    int error_count = 0;
    int idle_cycles = 0;

    // idling controls of the sender and the receiver
    int cmd_gap_max = 14;
    int rsp_stall_max = 14;
    int hold_request = 0;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic bit block_in_use(int blk);
        return map_words[blk / WORD_BITS][blk % WORD_BITS];
    endfunction

    function automatic void mark_block(int blk, bit in_use);
        map_words[blk / WORD_BITS][blk % WORD_BITS] = in_use;
    endfunction

    // applies one command to the predicted map and returns the response
    function automatic alloc_result_t apply_command(logic [CMD_W-1:0] op,
                                                   logic [BLK_W-1:0] blk);
        alloc_result_t res;
        int            lowest_free;
        res = '0;
        res.status = STAT_OK;
        lowest_free = -1;
        case (op)
            CMD_ALLOC:
            begin
                // lowest clear bit, word by word
                for (int w = 0; w < MAP_WORDS && lowest_free < 0; w++)
                begin
                    if (~map_words[w] != '0)
                    begin
                        for (int b = 0; b < WORD_BITS && lowest_free < 0; b++)
                        begin
                            if (!map_words[w][b])
                                lowest_free = w * WORD_BITS + b;
                        end
                    end
                end
                if (lowest_free < 0 || lowest_free >= NUM_BLOCKS)
                    res.status = STAT_FULL;
                else
                begin
                    mark_block(lowest_free, 1'b1);
                    blocks_used++;
                    res.granted_block = BLK_W'(lowest_free);
                end
            end
            CMD_REQUEST:
            begin
                // reserved blocks and anything past the end count as in use
                if (int'(blk) >= NUM_BLOCKS || block_in_use(int'(blk)))
                    res.status = STAT_IN_USE;
                else
                begin
                    mark_block(int'(blk), 1'b1);
                    blocks_used++;
                    res.granted_block = blk;
                end
            end
            CMD_RELEASE:
            begin
                // freeing a free block changes nothing and still succeeds
                if (int'(blk) < NUM_BLOCKS && block_in_use(int'(blk)))
                begin
                    mark_block(int'(blk), 1'b0);
                    blocks_used--;
                end
            end
            default:
            begin
                // no-op code: counts only
            end
        endcase
        res.used_count = CNT_W'(blocks_used);
        res.free_count = CNT_W'(NUM_BLOCKS - blocks_used);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // mismatch reporting
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint want,
                                   input longint got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // command sender: one transfer per call, inputs change on the falling edge
    // valid stays high across back-to-back commands
    // ------------------------------------------------------------------------
    task automatic send_command(input logic [CMD_W-1:0] op, input logic [BLK_W-1:0] blk);
        int            gap;
        alloc_result_t res;
        gap = (cmd_gap_max > 0) ? $urandom_range(0, cmd_gap_max) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= op;
        cmd_ch.target_block <= blk;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        // transfer taken at this edge: predict and queue the response
        res = apply_command(op, blk);
        expected_responses.push_back(res);
        if (res.status == STAT_OK && (op == CMD_ALLOC || op == CMD_REQUEST))
        begin
            granted_history.push_back(res.granted_block);
            if (granted_history.size() > 256)
                void'(granted_history.pop_front());
        end
    endtask

    // target mix: low blocks, anywhere, the reserved tail, or a block granted earlier
    function automatic logic [BLK_W-1:0] pick_target();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return BLK_W'($urandom_range(0, 300));
        if (pick < 6 || granted_history.size() == 0)
            return BLK_W'($urandom);
        if (pick == 6)
            return BLK_W'($urandom_range(NUM_BLOCKS - TAIL_BLOCKS, NUM_BLOCKS - 1));
        return granted_history[$urandom_range(0, granted_history.size() - 1)];
    endfunction

    // ------------------------------------------------------------------------
    // response receiver: draws a stall per response, or takes a long hold-off
    // when the pressure test asks for one
    // ------------------------------------------------------------------------
    initial
    begin : response_receiver
        int stall;
        rsp_ch.ready = 1'b0;
        while (!rst_n)
            @(negedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            else
            begin
                stall = (rsp_stall_max > 0) ? $urandom_range(0, rsp_stall_max) : 0;
                if (stall > 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid && hold_request == 0);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // response checker and activity counter, sampled on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : response_check
        alloc_result_t want;
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_responses.size() == 0)
                report_mismatch("response count (none pending)", 0, 1);
            else
            begin
                want = expected_responses.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", want.status, rsp_ch.status);
                if (rsp_ch.granted_block !== want.granted_block)
                    report_mismatch("granted_block", want.granted_block,
                                    rsp_ch.granted_block);
                if (rsp_ch.used_count !== want.used_count)
                    report_mismatch("used_count", want.used_count, rsp_ch.used_count);
                if (rsp_ch.free_count !== want.free_count)
                    report_mismatch("free_count", want.free_count, rsp_ch.free_count);
            end
        end
    end

    // watchdog: too long without any transfer ends the run
    initial
    begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("[%0t] no transfer for %0d cycles, %0d responses pending",
                 $time, WATCHDOG_LIMIT, expected_responses.size());
        $display("free_block_bitmap_allocator_top_test: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // extremes of the target field, every command code and the simple corner cases
    task automatic test_directed;
        cmd_gap_max = 14;
        rsp_stall_max = 14;
        send_command(CMD_ALLOC, 16'hFFFF);              // lowest free is block 0
        send_command(CMD_ALLOC, 16'h0000);              // then block 1
        send_command(CMD_REQUEST, 16'hFFFF);            // reserved tail: in use
        send_command(CMD_REQUEST, 16'(NUM_BLOCKS - TAIL_BLOCKS)); // first reserved
        send_command(CMD_REQUEST, 16'h0000);            // already allocated
        send_command(CMD_REQUEST, 16'd100);
        send_command(CMD_RELEASE, 16'hFFFF);            // releasing a reserved block
        send_command(CMD_REQUEST, 16'hFFFF);            // now it can be claimed
        send_command(CMD_RELEASE, 16'd7);               // release of a free block
        send_command(CMD_RELEASE, 16'd1);
        send_command(CMD_ALLOC, 16'h5555);              // fills the hole at 1
        send_command(CMD_NOP, 16'hFFFF);
        send_command(CMD_NOP, 16'h0000);
        send_command(CMD_RELEASE, 16'd100);
        send_command(CMD_REQUEST, 16'h5555);
        send_command(CMD_REQUEST, 16'hAAAA);
        send_command(CMD_REQUEST, 16'h5555);            // second claim fails
        send_command(CMD_RELEASE, 16'h5555);
        send_command(CMD_RELEASE, 16'hAAAA);
        send_command(CMD_RELEASE, 16'h0000);
        send_command(CMD_ALLOC, 16'hAAAA);              // block 0 again
        send_command(CMD_ALLOC, 16'h5555);
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_backpressure;
        cmd_gap_max = 0;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 16; i++)
        begin
            if (i % 2 == 0)
                send_command(CMD_ALLOC, pick_target());
            else
                send_command(CMD_REQUEST, pick_target());
        end
        cmd_gap_max = 14;
    endtask

    // random command mix with idling redrawn in stretches
    task automatic test_random(input int count);
        int               pick;
        logic [CMD_W-1:0] op;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        cmd_gap_max = 0;
                        rsp_stall_max = 0;
                    end
                    1:
                    begin
                        cmd_gap_max = 14;
                        rsp_stall_max = 0;
                    end
                    2:
                    begin
                        cmd_gap_max = 0;
                        rsp_stall_max = 14;
                    end
                    default:
                    begin
                        cmd_gap_max = 14;
                        rsp_stall_max = 14;
                    end
                endcase
            end
            pick = $urandom_range(0, 19);
            if (pick < 7)
                op = CMD_ALLOC;
            else if (pick < 12)
                op = CMD_REQUEST;
            else if (pick < 19)
                op = CMD_RELEASE;
            else
                op = CMD_NOP;
            send_command(op, (op == CMD_ALLOC) ? BLK_W'($urandom) : pick_target());
        end
        cmd_gap_max = 14;
        rsp_stall_max = 14;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        cmd_ch.valid = 1'b0;
        cmd_ch.command = CMD_NOP;
        cmd_ch.target_block = '0;

        // predicted state after reset: only the reserved tail is used
        foreach (map_words[w])
            map_words[w] = '0;
        for (int blk = NUM_BLOCKS - TAIL_BLOCKS; blk < NUM_BLOCKS; blk++)
            mark_block(blk, 1'b1);
        blocks_used = TAIL_BLOCKS;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random(420);
        // second random stretch on a map that already holds many blocks
        test_random(120);

        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (expected_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_responses.size() != 0)
            report_mismatch("responses left pending", 0, expected_responses.size());

        if (error_count == 0)
            $display("free_block_bitmap_allocator_top_test: clean");
        else
            $display("free_block_bitmap_allocator_top_test: errors");
        $finish;
    end

endmodule
